@@ sv/ita2_pkg.sv @@
`default_nettype none

package ita2_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [4:0] CODE_NULL = 5'd0;
  localparam logic [4:0] CODE_FIGS = 5'd27;
  localparam logic [4:0] CODE_LTRS = 5'd31;

  localparam logic [0:0] ACT_ENCODE = 1'b0;
  localparam logic [0:0] ACT_DECODE = 1'b1;

  localparam logic [7:0] CH_NONE = 8'd0;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_ENQ  = 8'd5;
  localparam logic [7:0] CH_BEL  = 8'd7;

  // one classified item waiting for the back end
  typedef struct packed {
    logic       need_shift;
    logic       to_figs;
    logic [4:0] code_out;
    logic       code_valid;
    logic       is_shift_code;
    logic [7:0] char_out;
    logic       char_valid;
    logic       error;
  } ita2_op_t;

  function automatic logic [7:0] letters_char(input logic [4:0] code);
    logic [7:0] c;
    unique case (code)
      5'd1:  c = "E";
      5'd2:  c = CH_LF;
      5'd3:  c = "A";
      5'd4:  c = " ";
      5'd5:  c = "S";
      5'd6:  c = "I";
      5'd7:  c = "U";
      5'd8:  c = CH_CR;
      5'd9:  c = "D";
      5'd10: c = "R";
      5'd11: c = "J";
      5'd12: c = "N";
      5'd13: c = "F";
      5'd14: c = "C";
      5'd15: c = "K";
      5'd16: c = "T";
      5'd17: c = "Z";
      5'd18: c = "L";
      5'd19: c = "W";
      5'd20: c = "H";
      5'd21: c = "Y";
      5'd22: c = "P";
      5'd23: c = "Q";
      5'd24: c = "O";
      5'd25: c = "B";
      5'd26: c = "G";
      5'd28: c = "M";
      5'd29: c = "X";
      5'd30: c = "V";
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] figures_char(input logic [4:0] code, input logic murray);
    logic [7:0] c;
    unique case (code)
      5'd1:  c = "3";
      5'd2:  c = CH_LF;
      5'd3:  c = "-";
      5'd4:  c = " ";
      5'd5:  c = "'";
      5'd6:  c = "8";
      5'd7:  c = "7";
      5'd8:  c = CH_CR;
      5'd9:  c = CH_ENQ;
      5'd10: c = "4";
      5'd11: c = murray ? "!" : CH_BEL;
      5'd12: c = ",";
      5'd13: c = "!";
      5'd14: c = ":";
      5'd15: c = "(";
      5'd16: c = "5";
      5'd17: c = "\"";
      5'd18: c = ")";
      5'd19: c = "2";
      5'd20: c = murray ? "+" : "#";
      5'd21: c = "6";
      5'd22: c = "0";
      5'd23: c = "1";
      5'd24: c = "9";
      5'd25: c = "?";
      5'd26: c = "&";
      5'd28: c = ".";
      5'd29: c = "/";
      5'd30: c = "=";
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // reverse lookups, CODE_NULL when the character is absent
  function automatic logic [4:0] letters_code(input logic [7:0] ch);
    logic [4:0] k;
    unique case (ch)
      "E":   k = 5'd1;
      CH_LF: k = 5'd2;
      "A":   k = 5'd3;
      " ":   k = 5'd4;
      "S":   k = 5'd5;
      "I":   k = 5'd6;
      "U":   k = 5'd7;
      CH_CR: k = 5'd8;
      "D":   k = 5'd9;
      "R":   k = 5'd10;
      "J":   k = 5'd11;
      "N":   k = 5'd12;
      "F":   k = 5'd13;
      "C":   k = 5'd14;
      "K":   k = 5'd15;
      "T":   k = 5'd16;
      "Z":   k = 5'd17;
      "L":   k = 5'd18;
      "W":   k = 5'd19;
      "H":   k = 5'd20;
      "Y":   k = 5'd21;
      "P":   k = 5'd22;
      "Q":   k = 5'd23;
      "O":   k = 5'd24;
      "B":   k = 5'd25;
      "G":   k = 5'd26;
      "M":   k = 5'd28;
      "X":   k = 5'd29;
      "V":   k = 5'd30;
      default: k = CODE_NULL;
    endcase
    return k;
  endfunction

  // duplicates resolve to the highest code, so '!' is always 13
  function automatic logic [4:0] figures_code(input logic [7:0] ch, input logic murray);
    logic [4:0] k;
    unique case (ch)
      "3":    k = 5'd1;
      CH_LF:  k = 5'd2;
      "-":    k = 5'd3;
      " ":    k = 5'd4;
      "'":    k = 5'd5;
      "8":    k = 5'd6;
      "7":    k = 5'd7;
      CH_CR:  k = 5'd8;
      CH_ENQ: k = 5'd9;
      "4":    k = 5'd10;
      CH_BEL: k = murray ? CODE_NULL : 5'd11;
      ",":    k = 5'd12;
      "!":    k = 5'd13;
      ":":    k = 5'd14;
      "(":    k = 5'd15;
      "5":    k = 5'd16;
      "\"":   k = 5'd17;
      ")":    k = 5'd18;
      "2":    k = 5'd19;
      "#":    k = murray ? CODE_NULL : 5'd20;
      "+":    k = murray ? 5'd20 : CODE_NULL;
      "6":    k = 5'd21;
      "0":    k = 5'd22;
      "1":    k = 5'd23;
      "9":    k = 5'd24;
      "?":    k = 5'd25;
      "&":    k = 5'd26;
      ".":    k = 5'd28;
      "/":    k = 5'd29;
      "=":    k = 5'd30;
      default: k = CODE_NULL;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ sv/ita2_front.sv @@
`default_nettype none

module ita2_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic              action,
  input  wire logic              first_of_message,
  input  wire logic [7:0]        char_in,
  input  wire logic [7:0]        code_in,
  input  wire logic              cfg_we,
  input  wire logic              cfg_data,
  input  wire logic              q_full,
  output      logic              q_push,
  output      ita2_pkg::ita2_op_t q_op
);
  import ita2_pkg::*;

  logic       figures_shift;
  logic       figures_shift_next;
  logic       murray_mode;
  logic       cur_shift;
  logic [7:0] ch_up;
  logic [4:0] lc;
  logic [4:0] fc;
  logic [4:0] code5;
  logic [7:0] dec_char;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    cur_shift = first_of_message ? 1'b0 : figures_shift;
    ch_up     = (char_in >= "a" && char_in <= "z") ? char_in - 8'd32 : char_in;
    lc        = letters_code(ch_up);
    fc        = figures_code(ch_up, murray_mode);
    code5     = code_in[4:0];
    dec_char  = cur_shift ? figures_char(code5, murray_mode) : letters_char(code5);

    q_op               = '0;
    figures_shift_next = cur_shift;
    if (action == ACT_ENCODE) begin
      // letters table wins over figures
      if (lc != CODE_NULL) begin
        q_op.code_out      = lc;
        q_op.code_valid    = 1'b1;
        q_op.need_shift    = cur_shift;
        q_op.to_figs       = 1'b0;
        figures_shift_next = 1'b0;
      end else if (fc != CODE_NULL) begin
        q_op.code_out      = fc;
        q_op.code_valid    = 1'b1;
        q_op.need_shift    = !cur_shift;
        q_op.to_figs       = 1'b1;
        figures_shift_next = 1'b1;
      end
    end else begin
      if (code_in[7:5] != 3'd0) begin
        q_op.error = 1'b1;
      end else if (code5 == CODE_LTRS || code5 == CODE_FIGS) begin
        q_op.is_shift_code = 1'b1;
        figures_shift_next = (code5 == CODE_FIGS);
      end else if (dec_char != CH_NONE) begin
        q_op.char_out   = dec_char;
        q_op.char_valid = 1'b1;
      end else begin
        q_op.error = (code5 != CODE_NULL);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      figures_shift <= 1'b0;
      murray_mode   <= 1'b0;
    end else begin
      if (q_push) figures_shift <= figures_shift_next;
      if (cfg_we) murray_mode <= cfg_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/ita2_fifo.sv @@
`default_nettype none

module ita2_fifo #(
  parameter int DEPTH = ita2_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ita2_pkg::ita2_op_t push_op,
  output      logic               full,
  input  wire logic               pop,
  output      logic               head_valid,
  output      ita2_pkg::ita2_op_t head
);
  import ita2_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ita2_op_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

@@ sv/ita2_back.sv @@
`default_nettype none

module ita2_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  wire ita2_pkg::ita2_op_t head,
  output      logic               pop,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [4:0]         code_out,
  output      logic               code_valid,
  output      logic               is_shift_code,
  output      logic [7:0]         char_out,
  output      logic               char_valid,
  output      logic               error,
  output      logic               last
);
  import ita2_pkg::*;

  logic load;
  logic shift_beat;
  logic sent_shift;

  assign load       = !out_valid || out_ready;
  // a pending shift code goes out as its own beat ahead of the data code
  assign shift_beat = head.need_shift && !sent_shift;
  assign pop        = load && head_valid && !shift_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      sent_shift <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) sent_shift <= shift_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (shift_beat) begin
        code_out      <= head.to_figs ? CODE_FIGS : CODE_LTRS;
        code_valid    <= 1'b1;
        is_shift_code <= 1'b1;
        char_out      <= CH_NONE;
        char_valid    <= 1'b0;
        error         <= 1'b0;
        last          <= 1'b0;
      end else begin
        code_out      <= head.code_out;
        code_valid    <= head.code_valid;
        is_shift_code <= head.is_shift_code;
        char_out      <= head.char_out;
        char_valid    <= head.char_valid;
        error         <= head.error;
        last          <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/ita2_shift_codec.sv @@
// ITA2 teleprinter codec between 8-bit characters and 5-bit codes with a
// letters/figures shift flag. Each input beat encodes char_in (action 0) or
// decodes code_in (action 1) and gives one result beat, or two when an encode
// needs a LTRS/FIGS code first; last marks the final beat of an item. The front
// end classifies an item in the cycle it is accepted and tracks the shift flag;
// a small queue (QUEUE_DEPTH entries) feeds the back end, whose output register
// sends one beat per cycle while out_ready is high. The front end takes a new item
// whenever the queue is not full, so it can accept one before the last has left.
// murray_mode is written through cfg_we/cfg_data and must only change while idle.
`default_nettype none

module ita2_shift_codec #(
  parameter int QUEUE_DEPTH = ita2_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic       action,
  input  wire logic       first_of_message,
  input  wire logic [7:0] char_in,
  input  wire logic [7:0] code_in,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [4:0] code_out,
  output      logic       code_valid,
  output      logic       is_shift_code,
  output      logic [7:0] char_out,
  output      logic       char_valid,
  output      logic       error,
  output      logic       last,
  input  wire logic       cfg_we,
  input  wire logic       cfg_data
);
  import ita2_pkg::*;

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     head_valid;
  ita2_op_t q_op;
  ita2_op_t head;

  ita2_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .first_of_message (first_of_message),
    .char_in          (char_in),
    .code_in          (code_in),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_op             (q_op)
  );

  ita2_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ita2_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_out      (code_out),
    .code_valid    (code_valid),
    .is_shift_code (is_shift_code),
    .char_out      (char_out),
    .char_valid    (char_valid),
    .error         (error),
    .last          (last)
  );

  // a non-final beat is always an emitted shift code
  a_first_is_shift: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> code_valid && is_shift_code &&
      (code_out == CODE_LTRS || code_out == CODE_FIGS))
    else $error("non-final beat is not a shift code");

  // the data beat follows its shift beat with no gap
  a_pair_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && last && code_valid)
    else $error("data beat did not follow shift beat");

  // encode and decode fields never mix in one beat
  a_no_mix: assert property (@(posedge clk) disable iff (rst)
    out_valid && (char_valid || error) |-> !code_valid && last)
    else $error("decode beat carries encode fields");

  // the queue never drops a classified item
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("push into full queue");

endmodule

`default_nettype wire
